// ----- hdl/edf_pkg.sv -----
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants for the earliest-deadline-first slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

   localparam int WORD_W     = 32;
   localparam int MAX_TASKS  = 4;
   localparam int TASK_W     = 2;
   localparam int CSR_ADDR_W = 3;

   localparam int NUM_TASKS_DEF  = 4;
   localparam int SLOT_TICKS_DEF = 1000;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_EXEC_BASE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_BASE = 3'd4;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [WORD_W-1:0] sum;
      logic              carry;
   } alu_res_type;

endpackage

`default_nettype wire

// ----- hdl/edf_alu.sv -----
// ----------------------------------------------------------------------------
// edf_alu
// Shared 32-bit add / subtract unit; carry out doubles as the not-less flag.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_alu (
   input  wire logic [edf_pkg::WORD_W-1:0] opa,
   input  wire logic [edf_pkg::WORD_W-1:0] opb,
   input  wire edf_pkg::alu_op_type        op,
   output edf_pkg::alu_res_type            res
);

   logic [edf_pkg::WORD_W-1:0] opb_x;
   logic                       cin;
   logic [edf_pkg::WORD_W:0]   total;

   always_comb begin
      cin   = (op == edf_pkg::ALU_SUB);
      opb_x = cin ? ~opb : opb;
      total = {1'b0, opa} + {1'b0, opb_x} + {{edf_pkg::WORD_W{1'b0}}, cin};
   end

   // for subtract, carry set means opa >= opb
   assign res.sum   = total[edf_pkg::WORD_W-1:0];
   assign res.carry = total[edf_pkg::WORD_W];

endmodule

`default_nettype wire

// ----- hdl/edf_slot_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// edf_slot_scheduler_top: earliest-deadline-first slot scheduler
// Each step of the scan makes one pass of the shared adder: unblock, retire
//   check, deadline add and compare per task, then the charge of the pick.
// Flow: ready only while idle, so a new slot waits until the last is done; a result
//   not yet taken holds the last step until the result register frees up.
// Reset: synchronous; all tasks ready, no task running, configuration registers cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_slot_scheduler_top #(
   parameter int NUM_TASKS  = edf_pkg::NUM_TASKS_DEF,
   parameter int SLOT_TICKS = edf_pkg::SLOT_TICKS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [edf_pkg::WORD_W-1:0]     req_now,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_run_valid,
   output logic [edf_pkg::TASK_W-1:0]          rsp_run_task,
   output logic [edf_pkg::MAX_TASKS-1:0]       rsp_blocked_mask,
   input  wire logic                           csr_we,
   input  wire logic [edf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [edf_pkg::WORD_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(NUM_TASKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
   localparam int W = edf_pkg::WORD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UNBLK,
      S_RET_CMP,
      S_RET_ADD,
      S_DL_ADD,
      S_DL_CMP,
      S_CHARGE
   } state_type;

   state_type                    state_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [W-1:0]                 now_ff;
   logic [W-1:0]                 release_ff [NUM_TASKS];
   logic [W-1:0]                 used_ff    [NUM_TASKS];
   logic [NUM_TASKS-1:0]         blocked_ff;
   logic                         cur_valid_ff;
   logic [edf_pkg::TASK_W-1:0]   cur_idx_ff;
   logic                         found_ff;
   logic [IDX_W-1:0]             best_ff;
   logic [W-1:0]                 dl_ff;
   logic [W-1:0]                 best_dl_ff;
   logic [W-1:0]                 exec_ff    [edf_pkg::MAX_TASKS];
   logic [W-1:0]                 period_ff  [edf_pkg::MAX_TASKS];
   logic                         rsp_valid_ff;
   logic                         rsp_run_valid_ff;
   logic [edf_pkg::TASK_W-1:0]   rsp_run_task_ff;
   logic [edf_pkg::MAX_TASKS-1:0] rsp_blocked_mask_ff;

   logic [IDX_W-1:0]             tsk;
   logic [edf_pkg::TASK_W-1:0]   tsk_cfg;
   logic [W-1:0]                 rel_rd;
   logic [W-1:0]                 used_rd;
   logic [W-1:0]                 exec_rd;
   logic [W-1:0]                 per_rd;
   logic                         candidate;
   logic                         cur_in_range;
   logic [edf_pkg::MAX_TASKS-1:0] mask_now;
   logic [W-1:0]                 alu_a;
   logic [W-1:0]                 alu_b;
   edf_pkg::alu_op_type          alu_op;
   edf_pkg::alu_res_type         alu_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < edf_pkg::MAX_TASKS; i++) begin
            exec_ff[i]   <= '0;
            period_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_addr >= edf_pkg::CSR_PERIOD_BASE) begin
            period_ff[csr_addr[edf_pkg::TASK_W-1:0]] <= csr_wdata;
         end else begin
            exec_ff[csr_addr[edf_pkg::TASK_W-1:0]] <= csr_wdata;
         end
      end
   end

   // one task entry is worked on at a time
   always_comb begin
      case (state_ff)
         S_RET_CMP, S_RET_ADD: tsk = cur_idx_ff[IDX_W-1:0];
         S_CHARGE:             tsk = best_ff;
         default:              tsk = idx_ff;
      endcase
   end

   assign tsk_cfg      = edf_pkg::TASK_W'(tsk);
   assign rel_rd       = release_ff[tsk];
   assign used_rd      = used_ff[tsk];
   assign exec_rd      = exec_ff[tsk_cfg];
   assign per_rd       = period_ff[tsk_cfg];
   assign candidate    = !blocked_ff[tsk] && (per_rd != '0);
   assign cur_in_range = ({1'b0, cur_idx_ff} < 3'(NUM_TASKS));

   always_comb begin
      mask_now = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         mask_now[i] = blocked_ff[i];
      end
   end

   always_comb begin
      case (state_ff)
         S_UNBLK: begin
            alu_a  = now_ff;
            alu_b  = rel_rd;
            alu_op = edf_pkg::ALU_SUB;
         end
         S_RET_CMP: begin
            alu_a  = used_rd;
            alu_b  = exec_rd;
            alu_op = edf_pkg::ALU_SUB;
         end
         S_RET_ADD, S_DL_ADD: begin
            alu_a  = rel_rd;
            alu_b  = per_rd;
            alu_op = edf_pkg::ALU_ADD;
         end
         S_DL_CMP: begin
            alu_a  = dl_ff;
            alu_b  = best_dl_ff;
            alu_op = edf_pkg::ALU_SUB;
         end
         S_CHARGE: begin
            alu_a  = used_rd;
            alu_b  = W'(SLOT_TICKS);
            alu_op = edf_pkg::ALU_ADD;
         end
         default: begin
            alu_a  = '0;
            alu_b  = '0;
            alu_op = edf_pkg::ALU_ADD;
         end
      endcase
   end

   edf_alu u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .op  (alu_op),
      .res (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         blocked_ff   <= '0;
         cur_valid_ff <= 1'b0;
         cur_idx_ff   <= '0;
         found_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            release_ff[i] <= '0;
            used_ff[i]    <= '0;
         end
      end else begin
         // the last step reloads the result register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_CHARGE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  now_ff   <= req_now;
                  idx_ff   <= '0;
                  state_ff <= S_UNBLK;
               end
            end
            S_UNBLK: begin
               // release time at or before now
               if (blocked_ff[tsk] && alu_res.carry) begin
                  blocked_ff[tsk] <= 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_RET_CMP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_RET_CMP: begin
               found_ff <= 1'b0;
               idx_ff   <= '0;
               if (cur_valid_ff && cur_in_range && alu_res.carry) begin
                  state_ff <= S_RET_ADD;
               end else begin
                  state_ff <= S_DL_ADD;
               end
            end
            S_RET_ADD: begin
               release_ff[tsk] <= alu_res.sum;
               used_ff[tsk]    <= '0;
               blocked_ff[tsk] <= 1'b1;
               state_ff        <= S_DL_ADD;
            end
            S_DL_ADD: begin
               if (candidate) begin
                  dl_ff    <= alu_res.sum;
                  state_ff <= S_DL_CMP;
               end else if (idx_ff == LAST_IDX) begin
                  state_ff <= S_CHARGE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DL_CMP: begin
               // strictly earlier deadline replaces, so a tie keeps the lower index
               if (!found_ff || !alu_res.carry) begin
                  found_ff   <= 1'b1;
                  best_ff    <= idx_ff;
                  best_dl_ff <= dl_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_CHARGE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_DL_ADD;
               end
            end
            S_CHARGE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  if (found_ff) begin
                     used_ff[tsk] <= alu_res.carry ? '1 : alu_res.sum;
                  end
                  cur_valid_ff        <= found_ff;
                  cur_idx_ff          <= found_ff ? edf_pkg::TASK_W'(best_ff) : '0;
                  rsp_run_valid_ff    <= found_ff;
                  rsp_run_task_ff     <= found_ff ? edf_pkg::TASK_W'(best_ff) : '0;
                  rsp_blocked_mask_ff <= mask_now;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_run_valid    = rsp_run_valid_ff;
   assign rsp_run_task     = rsp_run_task_ff;
   assign rsp_blocked_mask = rsp_blocked_mask_ff;

   a_accept_starts_scan : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_UNBLK)
      else $error("slot transfer did not start the unblock scan");

   a_idle_task_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_valid |-> rsp_run_task == '0)
      else $error("run_task nonzero with no task chosen");

   a_pick_is_ready : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHARGE && found_ff |-> !blocked_ff[best_ff] && per_rd != '0)
      else $error("chosen task is blocked or absent");

   a_cur_in_range : assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_in_range)
      else $error("running task index past task count");

   a_mask_upper_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blocked_mask & ~mask_now) == '0 || $past(rsp_valid))
      else $error("blocked mask changed after result was loaded");

endmodule

`default_nettype wire

// ----- verif/edf_slot_checker.sv -----
// ----------------------------------------------------------------------------
// edf_slot_checker
// Watches the slot, result and register ports of the EDF slot scheduler. It
// keeps its own copy of the task table and registers, works out the expected
// result of every slot transfer and compares results in order.
// ----------------------------------------------------------------------------

module edf_slot_checker #(
   parameter int NUM_TASKS  = edf_pkg::NUM_TASKS_DEF,
   parameter int SLOT_TICKS = edf_pkg::SLOT_TICKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [edf_pkg::WORD_W-1:0]     req_now,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_run_valid,
   input  logic [edf_pkg::TASK_W-1:0]     rsp_run_task,
   input  logic [edf_pkg::MAX_TASKS-1:0]  rsp_blocked_mask,
   input  logic                           csr_we,
   input  logic [edf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [edf_pkg::WORD_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);

   localparam int WORD_W    = edf_pkg::WORD_W;
   localparam int TASK_W    = edf_pkg::TASK_W;
   localparam int MAX_TASKS = edf_pkg::MAX_TASKS;

   typedef struct packed {
      logic                 run_valid;
      logic [TASK_W-1:0]    run_task;
      logic [MAX_TASKS-1:0] blocked_mask;
   } slot_result_type;

   // mirrored registers
   logic [WORD_W-1:0] budget [MAX_TASKS];
   logic [WORD_W-1:0] period [MAX_TASKS];

   // task table
   logic [WORD_W-1:0] release_at [MAX_TASKS];
   logic [WORD_W-1:0] used_ticks [MAX_TASKS];
   logic              waiting    [MAX_TASKS];
   logic              running_valid;
   logic [TASK_W-1:0] running_idx;

   slot_result_type schedule_q [$];
   int              errors = 0;

   function automatic slot_result_type schedule_slot(logic [WORD_W-1:0] now);
      slot_result_type   res;
      logic              found;
      int                pick;
      logic [WORD_W-1:0] best_dl;
      logic [WORD_W-1:0] dl;
      logic [WORD_W-1:0] charge;
      found   = 1'b0;
      pick    = 0;
      best_dl = '0;
      charge  = WORD_W'(SLOT_TICKS);
      for (int i = 0; i < NUM_TASKS; i++)
         if (waiting[i] && release_at[i] <= now)
            waiting[i] = 1'b0;
      // task that ran last slot: out of budget means wait for next release
      if (running_valid && int'(running_idx) < NUM_TASKS &&
          used_ticks[running_idx] >= budget[running_idx]) begin
         waiting[running_idx]    = 1'b1;
         release_at[running_idx] = release_at[running_idx] + period[running_idx];
         used_ticks[running_idx] = '0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (!waiting[i] && period[i] != '0) begin
            dl = release_at[i] + period[i];
            if (!found || dl < best_dl) begin
               found   = 1'b1;
               pick    = i;
               best_dl = dl;
            end
         end
      end
      running_valid = found;
      running_idx   = found ? TASK_W'(pick) : '0;
      if (found)
         used_ticks[pick] = (used_ticks[pick] > '1 - charge) ? '1 : used_ticks[pick] + charge;
      res.run_valid    = found;
      res.run_task     = running_idx;
      res.blocked_mask = '0;
      for (int i = 0; i < NUM_TASKS; i++)
         res.blocked_mask[i] = waiting[i];
      return res;
   endfunction

   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            budget[i]     = '0;
            period[i]     = '0;
            release_at[i] = '0;
            used_ticks[i] = '0;
            waiting[i]    = 1'b0;
         end
         running_valid = 1'b0;
         running_idx   = '0;
         schedule_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr < edf_pkg::CSR_PERIOD_BASE)
               budget[csr_addr - edf_pkg::CSR_EXEC_BASE] = csr_wdata;
            else
               period[csr_addr - edf_pkg::CSR_PERIOD_BASE] = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (schedule_q.size() == 0) begin
               $error("result transfer with no slot outstanding");
               errors++;
            end else begin
               want = schedule_q.pop_front();
               if (rsp_run_valid !== want.run_valid) begin
                  $error("run_valid: expected %0d, got %0d", want.run_valid, rsp_run_valid);
                  errors++;
               end
               if (rsp_run_task !== want.run_task) begin
                  $error("run_task: expected %0d, got %0d", want.run_task, rsp_run_task);
                  errors++;
               end
               if (rsp_blocked_mask !== want.blocked_mask) begin
                  $error("blocked_mask: expected %b, got %b",
                         want.blocked_mask, rsp_blocked_mask);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            schedule_q.push_back(schedule_slot(req_now));
      end
      fail_count  <= errors;
      outstanding <= schedule_q.size();
   end

endmodule

// ----- verif/tb_edf_slot_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tb_edf_slot_scheduler_top
// Drives scheduler slots and register settings into the EDF slot scheduler:
// a directed opening on ties, absent tasks, zero and full budgets and
// wrapping deadlines, then random task sets with mostly steady tick streams.
// ----------------------------------------------------------------------------

module tb_edf_slot_scheduler_top;

   localparam int NUM_TASKS    = edf_pkg::NUM_TASKS_DEF;
   localparam int SLOT_TICKS   = edf_pkg::SLOT_TICKS_DEF;
   localparam int RANDOM_SLOTS = 800;

   localparam int WORD_W     = edf_pkg::WORD_W;
   localparam int TASK_W     = edf_pkg::TASK_W;
   localparam int MAX_TASKS  = edf_pkg::MAX_TASKS;
   localparam int CSR_ADDR_W = edf_pkg::CSR_ADDR_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXEC_BASE   = edf_pkg::CSR_EXEC_BASE;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_BASE = edf_pkg::CSR_PERIOD_BASE;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_W-1:0]     req_now   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_run_valid;
   logic [TASK_W-1:0]     rsp_run_task;
   logic [MAX_TASKS-1:0]  rsp_blocked_mask;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [WORD_W-1:0]     csr_wdata = '0;

   int fail_count;
   int outstanding;

   int snd_idle_pct = 33;
   int rcv_idle_pct = 65;

   logic [WORD_W-1:0] cfg_budget [MAX_TASKS];
   logic [WORD_W-1:0] cfg_period [MAX_TASKS];
   logic [WORD_W-1:0] last_now = '0;

   int slots_sent    = 0;
   int random_slots  = 0;
   int settings_used = 0;
   int drain_pauses  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

   edf_slot_scheduler_top #(
      .NUM_TASKS (NUM_TASKS),
      .SLOT_TICKS(SLOT_TICKS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_valid   (rsp_run_valid),
      .rsp_run_task    (rsp_run_task),
      .rsp_blocked_mask(rsp_blocked_mask),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   edf_slot_checker #(
      .NUM_TASKS (NUM_TASKS),
      .SLOT_TICKS(SLOT_TICKS)
   ) slot_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_valid   (rsp_run_valid),
      .rsp_run_task    (rsp_run_task),
      .rsp_blocked_mask(rsp_blocked_mask),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // some registers get a throwaway value first, then the real one
   task automatic load_settings();
      for (int t = 0; t < MAX_TASKS; t++) begin
         if ($urandom_range(3) == 0)
            write_reg(CSR_ADDR_W'(CSR_EXEC_BASE + t), $urandom);
         write_reg(CSR_ADDR_W'(CSR_EXEC_BASE + t), cfg_budget[t]);
         if ($urandom_range(3) == 0)
            write_reg(CSR_ADDR_W'(CSR_PERIOD_BASE + t), $urandom);
         write_reg(CSR_ADDR_W'(CSR_PERIOD_BASE + t), cfg_period[t]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // always waits on the clock before returning, so valid is never lowered and raised in one step
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_slot(input logic [WORD_W-1:0] now_val);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < snd_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now   <= now_val;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      last_now = now_val;
      slots_sent++;
   endtask

   initial begin
      #5_000_000;
      $display("** edf_slot_scheduler_top: FAILED **");
      $finish;
   end

   initial begin
      int                kind;
      int                len;
      int                pause_at;
      int                scen;
      logic [WORD_W-1:0] now_val;
      scen = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all periods zero after reset: nothing may run
      send_slot('0);
      wait_drained();

      // mixed budgets, absent task, task with the full period
      cfg_budget = '{2 * SLOT_TICKS, SLOT_TICKS, 0, '1};
      cfg_period = '{5 * SLOT_TICKS, 3 * SLOT_TICKS, 0, '1};
      load_settings();
      for (int k = 0; k < 10; k++)
         send_slot(WORD_W'(k * SLOT_TICKS));
      send_slot('1);
      send_slot('0);
      wait_drained();

      // equal deadlines, zero budget, deadline that wraps after one retire
      cfg_budget = '{0, SLOT_TICKS, 3 * SLOT_TICKS, SLOT_TICKS};
      cfg_period = '{4 * SLOT_TICKS, 4 * SLOT_TICKS, 4 * SLOT_TICKS, 32'hFFFF_F000};
      load_settings();
      for (int k = 0; k < 8; k++)
         send_slot(last_now + WORD_W'(SLOT_TICKS));
      send_slot('1);
      send_slot('1);
      send_slot(32'd500);

      while (random_slots < RANDOM_SLOTS) begin
         if (random_slots < RANDOM_SLOTS / 3) begin
            snd_idle_pct = 33;
            rcv_idle_pct = 65;
         end else if (random_slots < 2 * RANDOM_SLOTS / 3) begin
            snd_idle_pct = 65;
            rcv_idle_pct = 33;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end

         if (scen == 0 || $urandom_range(3) != 0) begin
            for (int t = 0; t < MAX_TASKS; t++) begin
               case ($urandom_range(7))
                  0:       cfg_period[t] = '0;
                  1:       cfg_period[t] = '1;
                  2:       cfg_period[t] = $urandom;
                  3:       cfg_period[t] = '1 - $urandom_range(20000);
                  default: cfg_period[t] = SLOT_TICKS * $urandom_range(2, 12);
               endcase
               case ($urandom_range(7))
                  0:       cfg_budget[t] = '0;
                  1:       cfg_budget[t] = '1;
                  2:       cfg_budget[t] = $urandom;
                  default: cfg_budget[t] = SLOT_TICKS * $urandom_range(0, 4) + $urandom_range(1);
               endcase
            end
            wait_drained();
            load_settings();
         end

         // start point of the tick stream; most streams carry on from the last tick
         case ($urandom_range(7))
            0:       last_now = '1 - $urandom_range(30000);
            1:       last_now = $urandom;
            default: ;
         endcase

         kind     = $urandom_range(9);
         len      = $urandom_range(16, 48);
         pause_at = (scen == 0 || $urandom_range(3) == 0) ? $urandom_range(1, len - 1) : -1;
         for (int k = 0; k < len; k++) begin
            if (k == pause_at) begin
               wait_drained();
               drain_pauses++;
            end
            if (kind == 0) begin
               now_val = $urandom;
            end else begin
               case ($urandom_range(19))
                  0:       now_val = last_now;
                  1:       now_val = last_now + $urandom_range(1, 5000);
                  2:       now_val = last_now + $urandom;
                  3:       now_val = last_now - $urandom_range(1, 3000);
                  default: now_val = last_now + WORD_W'(SLOT_TICKS);
               endcase
            end
            send_slot(now_val);
            random_slots++;
         end
         scen++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d slots (%0d random) over %0d register settings, %0d drain pauses",
               slots_sent, random_slots, settings_used, drain_pauses);
      if (fail_count == 0)
         $display("** edf_slot_scheduler_top: PASSED **");
      else
         $display("** edf_slot_scheduler_top: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/edf_pkg.sv
hdl/edf_alu.sv
hdl/edf_slot_scheduler_top.sv
verif/edf_slot_checker.sv
verif/tb_edf_slot_scheduler_top.sv
